// ===== rtl/core/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, scale reciprocals, register indexes, config and stage-enable
// structs for the pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Fraction bits of the scaled readings (signed Q.FRAC_BITS).
  localparam int FRAC_BITS = 24;

  localparam int RAW_W   = 24;
  localparam int POUT_W  = 32;
  localparam int TOUT_W  = 24;
  localparam int C12_W   = 12;
  localparam int C16_W   = 16;

  // Reciprocal and scaled reading widths; the smallest scale factor sets both.
  localparam int RECIP_W = FRAC_BITS + 7;
  localparam int X_W     = FRAC_BITS + 7;
  localparam int SPROD_W = RAW_W + RECIP_W + 1;

  // Polynomial datapath widths.
  localparam int A_W     = X_W + C16_W;
  localparam int Y_W     = X_W + A_W - FRAC_BITS + 1;
  localparam int YL_W    = Y_W / 2;
  localparam int YH_W    = Y_W - YL_W;
  localparam int PP_W    = X_W + YL_W + 1;
  localparam int PROD_W  = X_W + Y_W;
  localparam int Q_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W   = Q_W + 1;
  localparam int TACC_W  = X_W + C12_W + 1;

  localparam int NUM_STAGES = 13;

  // Scale factors selected by the oversampling code.
  localparam longint unsigned SCALE_K0 = 64'd524288;
  localparam longint unsigned SCALE_K1 = 64'd1572864;
  localparam longint unsigned SCALE_K2 = 64'd3670016;
  localparam longint unsigned SCALE_K3 = 64'd7864320;
  localparam longint unsigned SCALE_K4 = 64'd253952;
  localparam longint unsigned SCALE_K5 = 64'd516096;
  localparam longint unsigned SCALE_K6 = 64'd1040384;
  localparam longint unsigned SCALE_K7 = 64'd2088960;

  localparam longint unsigned RECIP_ONE = 64'd1 << (FRAC_BITS + RAW_W);

  localparam longint unsigned RECIP_0 = (RECIP_ONE + SCALE_K0 / 2) / SCALE_K0;
  localparam longint unsigned RECIP_1 = (RECIP_ONE + SCALE_K1 / 2) / SCALE_K1;
  localparam longint unsigned RECIP_2 = (RECIP_ONE + SCALE_K2 / 2) / SCALE_K2;
  localparam longint unsigned RECIP_3 = (RECIP_ONE + SCALE_K3 / 2) / SCALE_K3;
  localparam longint unsigned RECIP_4 = (RECIP_ONE + SCALE_K4 / 2) / SCALE_K4;
  localparam longint unsigned RECIP_5 = (RECIP_ONE + SCALE_K5 / 2) / SCALE_K5;
  localparam longint unsigned RECIP_6 = (RECIP_ONE + SCALE_K6 / 2) / SCALE_K6;
  localparam longint unsigned RECIP_7 = (RECIP_ONE + SCALE_K7 / 2) / SCALE_K7;

  localparam logic [RECIP_W-1:0] RECIP_TAB [8] = '{
    RECIP_W'(RECIP_0), RECIP_W'(RECIP_1), RECIP_W'(RECIP_2), RECIP_W'(RECIP_3),
    RECIP_W'(RECIP_4), RECIP_W'(RECIP_5), RECIP_W'(RECIP_6), RECIP_W'(RECIP_7)
  };

  // Configuration port.
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_C0_C1       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C00         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C10         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C01_C11     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C20_C21_C30 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P_OSR       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_T_OSR       = 3'd6;

  typedef struct packed {
    logic [23:0] c0_c1;
    logic [19:0] c00;
    logic [19:0] c10;
    logic [31:0] c01_c11;
    logic [47:0] c20_c21_c30;
    logic [2:0]  p_osr;
    logic [2:0]  t_osr;
  } bsc_cfg_t;

  // Stage enables of the reading scaler.
  typedef struct packed {
    logic mul;
    logic rnd;
  } bsc_scale_en_t;

  // Stage enables of the fixed-point multiplier.
  typedef struct packed {
    logic part;
    logic sum;
    logic rnd;
  } bsc_qmul_en_t;

endpackage

// ===== rtl/core/bsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compensation coefficient registers
// APB-style register file holding the calibration coefficients and the
// oversampling codes of both channels.
// ----------------------------------------------------------------------------
module bsc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsc_pkg::CFG_AW-1:0]    paddr,
  input  logic [bsc_pkg::CFG_DW-1:0]    pwdata,
  output logic [bsc_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output bsc_pkg::bsc_cfg_t             cfg
);

  bsc_pkg::bsc_cfg_t               cfg_r;
  bsc_pkg::bsc_cfg_t               cfg_nxt;
  logic                            wr;
  logic [bsc_pkg::CFG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  // Registers sit on 8-byte boundaries.
  assign idx    = paddr[bsc_pkg::CFG_AW-1:bsc_pkg::CFG_AW-bsc_pkg::CFG_IDX_W];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        bsc_pkg::REG_C0_C1:       cfg_nxt.c0_c1       = pwdata[23:0];
        bsc_pkg::REG_C00:         cfg_nxt.c00         = pwdata[19:0];
        bsc_pkg::REG_C10:         cfg_nxt.c10         = pwdata[19:0];
        bsc_pkg::REG_C01_C11:     cfg_nxt.c01_c11     = pwdata[31:0];
        bsc_pkg::REG_C20_C21_C30: cfg_nxt.c20_c21_c30 = pwdata[47:0];
        bsc_pkg::REG_P_OSR:       cfg_nxt.p_osr       = pwdata[2:0];
        bsc_pkg::REG_T_OSR:       cfg_nxt.t_osr       = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      bsc_pkg::REG_C0_C1:       prdata = bsc_pkg::CFG_DW'(cfg_r.c0_c1);
      bsc_pkg::REG_C00:         prdata = bsc_pkg::CFG_DW'(cfg_r.c00);
      bsc_pkg::REG_C10:         prdata = bsc_pkg::CFG_DW'(cfg_r.c10);
      bsc_pkg::REG_C01_C11:     prdata = bsc_pkg::CFG_DW'(cfg_r.c01_c11);
      bsc_pkg::REG_C20_C21_C30: prdata = bsc_pkg::CFG_DW'(cfg_r.c20_c21_c30);
      bsc_pkg::REG_P_OSR:       prdata = bsc_pkg::CFG_DW'(cfg_r.p_osr);
      bsc_pkg::REG_T_OSR:       prdata = bsc_pkg::CFG_DW'(cfg_r.t_osr);
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/bsc_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading scaler
// Two-stage unit that divides a raw 24-bit reading by its oversampling scale
// factor through a multiply with the rounded reciprocal.
// ----------------------------------------------------------------------------
module bsc_scale (
  input  logic                                clk,
  input  bsc_pkg::bsc_scale_en_t              en,
  input  logic [bsc_pkg::RAW_W-1:0]           raw,
  input  logic [2:0]                          code,
  output logic signed [bsc_pkg::X_W-1:0]      x
);

  logic [bsc_pkg::RECIP_W-1:0]         recip;
  logic signed [bsc_pkg::SPROD_W-1:0]  prod_nxt;
  logic signed [bsc_pkg::SPROD_W-1:0]  prod_r;
  logic signed [bsc_pkg::SPROD_W-1:0]  half_c;
  logic signed [bsc_pkg::SPROD_W-1:0]  rsum;
  logic signed [bsc_pkg::X_W-1:0]      x_nxt;
  logic signed [bsc_pkg::X_W-1:0]      x_r;

  assign recip    = bsc_pkg::RECIP_TAB[code];
  assign prod_nxt = $signed(raw) * $signed({1'b0, recip});

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // Round to nearest, ties upward, on the 24 bits dropped.
  assign half_c = bsc_pkg::SPROD_W'(1) <<< (bsc_pkg::RAW_W - 1);
  assign rsum   = prod_r + half_c;
  assign x_nxt  = bsc_pkg::X_W'(rsum >>> bsc_pkg::RAW_W);

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      x_r <= x_nxt;
    end
  end

  assign x = x_r;

endmodule

// ===== rtl/core/bsc_qmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Three-stage signed Q-format product: two partial products, their sum, then
// a shift by the fraction bits rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module bsc_qmul (
  input  logic                               clk,
  input  bsc_pkg::bsc_qmul_en_t              en,
  input  logic signed [bsc_pkg::X_W-1:0]     x_in,
  input  logic signed [bsc_pkg::Y_W-1:0]     y_in,
  output logic signed [bsc_pkg::Q_W-1:0]     q
);

  logic signed [bsc_pkg::PP_W-1:0]    lo_nxt;
  logic signed [bsc_pkg::PP_W-1:0]    hi_nxt;
  logic signed [bsc_pkg::PP_W-1:0]    lo_r;
  logic signed [bsc_pkg::PP_W-1:0]    hi_r;
  logic signed [bsc_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [bsc_pkg::PROD_W-1:0]  prod_r;
  logic signed [bsc_pkg::PROD_W-1:0]  half_c;
  logic signed [bsc_pkg::PROD_W-1:0]  bias;
  logic signed [bsc_pkg::PROD_W-1:0]  rsum;
  logic signed [bsc_pkg::Q_W-1:0]     q_nxt;
  logic signed [bsc_pkg::Q_W-1:0]     q_r;

  // The wide operand is split into an unsigned low half and a signed high half.
  assign lo_nxt = x_in * $signed({1'b0, y_in[bsc_pkg::YL_W-1:0]});
  assign hi_nxt = x_in * $signed(y_in[bsc_pkg::Y_W-1:bsc_pkg::YL_W]);

  always_ff @(posedge clk) begin
    if (en.part) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign prod_nxt = (bsc_pkg::PROD_W'(hi_r) <<< bsc_pkg::YL_W) + bsc_pkg::PROD_W'(lo_r);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      prod_r <= prod_nxt;
    end
  end

  // A negative product takes half minus one, which rounds its magnitude
  // half away from zero under the flooring shift.
  assign half_c = bsc_pkg::PROD_W'(1) <<< (bsc_pkg::FRAC_BITS - 1);
  assign bias   = prod_r[bsc_pkg::PROD_W-1] ? (half_c - bsc_pkg::PROD_W'(1)) : half_c;
  assign rsum   = prod_r + bias;
  assign q_nxt  = bsc_pkg::Q_W'(rsum >>> bsc_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/baro_sensor_compensation_core.sv =====
`timescale 1ns / 1ps
// Throughput: one reading pair per cycle while out_tready is high; each stage
// moves when it is empty or the stage after it moves, so bubbles close up under
// output backpressure. The chain of multipliers (scale, coefficient, two
// Q-format products) sets the depth. Synchronous active-low reset clears valid
// bits and coefficients.
// ----------------------------------------------------------------------------
// Barometric sensor compensation core
// Scales raw pressure and temperature readings and evaluates the calibration
// polynomials in a 13-stage fixed-point pipeline with saturating outputs.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bsc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [bsc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [bsc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [47:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] pressure_out, [55:32] temperature_out
  output logic [55:0]                   out_tdata
);

  localparam int N = bsc_pkg::NUM_STAGES;

  bsc_pkg::bsc_cfg_t       cfg;
  bsc_pkg::bsc_scale_en_t  scale_en;
  bsc_pkg::bsc_qmul_en_t   q1_en;
  bsc_pkg::bsc_qmul_en_t   q2_en;

  logic [N:1]    v_r;
  logic [N:1]    v_nxt;
  logic [N+1:1]  en;

  logic signed [bsc_pkg::C12_W-1:0] c0;
  logic signed [bsc_pkg::C12_W-1:0] c1;
  logic signed [19:0]               c00;
  logic signed [19:0]               c10;
  logic signed [bsc_pkg::C16_W-1:0] c01;
  logic signed [bsc_pkg::C16_W-1:0] c11;
  logic signed [bsc_pkg::C16_W-1:0] c20;
  logic signed [bsc_pkg::C16_W-1:0] c21;
  logic signed [bsc_pkg::C16_W-1:0] c30;

  logic signed [bsc_pkg::X_W-1:0]    p2;
  logic signed [bsc_pkg::X_W-1:0]    t2;
  logic signed [bsc_pkg::X_W-1:0]    p_r [3:8];
  logic signed [bsc_pkg::X_W-1:0]    t_r [3:8];

  logic signed [bsc_pkg::A_W-1:0]    c30p_nxt;
  logic signed [bsc_pkg::A_W-1:0]    c30p_r;
  logic signed [bsc_pkg::A_W-1:0]    c21p_nxt;
  logic signed [bsc_pkg::A_W-1:0]    c21p_r;
  logic signed [bsc_pkg::TACC_W-1:0] c1t_nxt;
  logic signed [bsc_pkg::TACC_W-1:0] c1t_r;

  logic signed [bsc_pkg::A_W-1:0]    a_nxt;
  logic signed [bsc_pkg::A_W-1:0]    a_r;
  logic signed [bsc_pkg::A_W-1:0]    e_nxt;
  logic signed [bsc_pkg::A_W-1:0]    e_r;
  logic signed [bsc_pkg::TACC_W-1:0] tacc_nxt;
  logic signed [bsc_pkg::TACC_W-1:0] tacc_r;

  logic signed [bsc_pkg::TACC_W-1:0] thalf_c;
  logic signed [bsc_pkg::TACC_W-1:0] tmax_c;
  logic signed [bsc_pkg::TACC_W-1:0] tmin_c;
  logic signed [bsc_pkg::TACC_W-1:0] tsh;
  logic signed [bsc_pkg::TOUT_W-1:0] tout_nxt;
  logic signed [bsc_pkg::TOUT_W-1:0] tout_r [5:N];

  logic signed [bsc_pkg::Q_W-1:0]    qa;
  logic signed [bsc_pkg::Q_W-1:0]    qe;
  logic signed [bsc_pkg::Y_W-1:0]    b_nxt;
  logic signed [bsc_pkg::Y_W-1:0]    b_r;
  logic signed [bsc_pkg::Y_W-1:0]    g_nxt;
  logic signed [bsc_pkg::Y_W-1:0]    g_r;

  logic signed [bsc_pkg::Q_W-1:0]    qpb;
  logic signed [bsc_pkg::Q_W-1:0]    qtg;
  logic signed [bsc_pkg::ACC_W-1:0]  pacc_nxt;
  logic signed [bsc_pkg::ACC_W-1:0]  pacc_r;

  logic signed [bsc_pkg::ACC_W-1:0]  phalf_c;
  logic signed [bsc_pkg::ACC_W-1:0]  pmax_c;
  logic signed [bsc_pkg::ACC_W-1:0]  pmin_c;
  logic signed [bsc_pkg::ACC_W-1:0]  psh;
  logic signed [bsc_pkg::POUT_W-1:0] pout_nxt;
  logic signed [bsc_pkg::POUT_W-1:0] pout_r;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  bsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign c0  = cfg.c0_c1[23:12];
  assign c1  = cfg.c0_c1[11:0];
  assign c00 = cfg.c00;
  assign c10 = cfg.c10;
  assign c01 = cfg.c01_c11[31:16];
  assign c11 = cfg.c01_c11[15:0];
  assign c20 = cfg.c20_c21_c30[47:32];
  assign c21 = cfg.c20_c21_c30[31:16];
  assign c30 = cfg.c20_c21_c30[15:0];

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its data moves on.
  // --------------------------------------------------------------------------
  assign en[N+1] = out_tready;

  for (genvar i = 1; i <= N; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_comb begin
    v_nxt[1] = en[1] ? in_tvalid : v_r[1];
    for (int i = 2; i <= N; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[N];

  // --------------------------------------------------------------------------
  // Stages 1-2: scaled readings
  // --------------------------------------------------------------------------
  assign scale_en = '{mul: en[1], rnd: en[2]};

  bsc_scale u_scale_p (
    .clk  (clk),
    .en   (scale_en),
    .raw  (in_tdata[23:0]),
    .code (cfg.p_osr),
    .x    (p2)
  );

  bsc_scale u_scale_t (
    .clk  (clk),
    .en   (scale_en),
    .raw  (in_tdata[47:24]),
    .code (cfg.t_osr),
    .x    (t2)
  );

  // Scaled readings ride along until the last products need them.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_r[3] <= p2;
      t_r[3] <= t2;
    end
  end

  for (genvar i = 4; i <= 8; i++) begin : g_xline
    always_ff @(posedge clk) begin
      if (en[i]) begin
        p_r[i] <= p_r[i-1];
        t_r[i] <= t_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: coefficient products
  // --------------------------------------------------------------------------
  assign c30p_nxt = c30 * p2;
  assign c21p_nxt = c21 * p2;
  assign c1t_nxt  = c1 * t2;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c30p_r <= c30p_nxt;
      c21p_r <= c21p_nxt;
      c1t_r  <= c1t_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: inner polynomial terms and the temperature accumulator
  // --------------------------------------------------------------------------
  assign a_nxt    = (bsc_pkg::A_W'(c20) <<< bsc_pkg::FRAC_BITS) + c30p_r;
  assign e_nxt    = (bsc_pkg::A_W'(c11) <<< bsc_pkg::FRAC_BITS) + c21p_r;
  assign tacc_nxt = (bsc_pkg::TACC_W'(c0) <<< (bsc_pkg::FRAC_BITS - 1)) + c1t_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a_r    <= a_nxt;
      e_r    <= e_nxt;
      tacc_r <= tacc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: temperature output conversion; the result then rides along.
  // --------------------------------------------------------------------------
  assign thalf_c = bsc_pkg::TACC_W'(1) <<< (bsc_pkg::FRAC_BITS - 9);
  assign tmax_c  = bsc_pkg::TACC_W'(24'h7F_FFFF);
  assign tmin_c  = ~tmax_c;
  assign tsh     = (tacc_r + thalf_c) >>> (bsc_pkg::FRAC_BITS - 8);

  always_comb begin
    if (tsh > tmax_c) begin
      tout_nxt = bsc_pkg::TOUT_W'(tmax_c);
    end else if (tsh < tmin_c) begin
      tout_nxt = bsc_pkg::TOUT_W'(tmin_c);
    end else begin
      tout_nxt = bsc_pkg::TOUT_W'(tsh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tout_r[5] <= tout_nxt;
    end
  end

  for (genvar i = 6; i <= N; i++) begin : g_tline
    always_ff @(posedge clk) begin
      if (en[i]) begin
        tout_r[i] <= tout_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5-7: P*a and P*e
  // --------------------------------------------------------------------------
  assign q1_en = '{part: en[5], sum: en[6], rnd: en[7]};

  bsc_qmul u_qmul_pa (
    .clk  (clk),
    .en   (q1_en),
    .x_in (p_r[4]),
    .y_in (bsc_pkg::Y_W'(a_r)),
    .q    (qa)
  );

  bsc_qmul u_qmul_pe (
    .clk  (clk),
    .en   (q1_en),
    .x_in (p_r[4]),
    .y_in (bsc_pkg::Y_W'(e_r)),
    .q    (qe)
  );

  // --------------------------------------------------------------------------
  // Stage 8: b and g
  // --------------------------------------------------------------------------
  assign b_nxt = (bsc_pkg::Y_W'(c10) <<< bsc_pkg::FRAC_BITS) + bsc_pkg::Y_W'(qa);
  assign g_nxt = (bsc_pkg::Y_W'(c01) <<< bsc_pkg::FRAC_BITS) + bsc_pkg::Y_W'(qe);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      b_r <= b_nxt;
      g_r <= g_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9-11: P*b and T*g
  // --------------------------------------------------------------------------
  assign q2_en = '{part: en[9], sum: en[10], rnd: en[11]};

  bsc_qmul u_qmul_pb (
    .clk  (clk),
    .en   (q2_en),
    .x_in (p_r[8]),
    .y_in (b_r),
    .q    (qpb)
  );

  bsc_qmul u_qmul_tg (
    .clk  (clk),
    .en   (q2_en),
    .x_in (t_r[8]),
    .y_in (g_r),
    .q    (qtg)
  );

  // --------------------------------------------------------------------------
  // Stage 12: pressure accumulator
  // --------------------------------------------------------------------------
  assign pacc_nxt = (bsc_pkg::ACC_W'(c00) <<< bsc_pkg::FRAC_BITS)
                  + bsc_pkg::ACC_W'(qpb) + bsc_pkg::ACC_W'(qtg);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      pacc_r <= pacc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: pressure output conversion and the output register
  // --------------------------------------------------------------------------
  assign phalf_c = bsc_pkg::ACC_W'(1) <<< (bsc_pkg::FRAC_BITS - 7);
  assign pmax_c  = bsc_pkg::ACC_W'(32'h7FFF_FFFF);
  assign pmin_c  = ~pmax_c;
  assign psh     = (pacc_r + phalf_c) >>> (bsc_pkg::FRAC_BITS - 6);

  always_comb begin
    if (psh > pmax_c) begin
      pout_nxt = bsc_pkg::POUT_W'(pmax_c);
    end else if (psh < pmin_c) begin
      pout_nxt = bsc_pkg::POUT_W'(pmin_c);
    end else begin
      pout_nxt = bsc_pkg::POUT_W'(psh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[N]) begin
      pout_r <= pout_nxt;
    end
  end

  assign out_tdata = {tout_r[N], pout_r};

`ifndef SYNTH
  // A ready sink lets every stage move, so the input side must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready is high");

  // Items in flight change only by input and output transactions.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) == $past($countones(v_r))
                                 + int'($past(in_tvalid && in_tready))
                                 - int'($past(out_tvalid && out_tready))))
    else $error("pipeline occupancy does not match transactions");

  // A full pipeline with a stalled output must refuse new input.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_tready) |-> !in_tready)
    else $error("input accepted into a full stalled pipeline");
`endif

endmodule

// ===== test/tb_baro_sensor_compensation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation core testbench
// Programs the calibration coefficients and oversampling codes over the
// register port, streams raw reading pairs into the core, and compares every
// compensated pressure and temperature against a bit-exact fixed-point
// predictor. Both stream sides idle at random; one phase stalls the output
// long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_core;

  localparam int FRAC = 24;
  localparam logic [bsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 200;

  typedef logic signed [127:0] wide_t;

  localparam wide_t Q_SAT = (wide_t'(1) <<< 63) - 1;
  localparam wide_t P_MAX = (wide_t'(1) <<< 31) - 1;
  localparam wide_t P_MIN = -(wide_t'(1) <<< 31);
  localparam wide_t T_MAX = (wide_t'(1) <<< 23) - 1;
  localparam wide_t T_MIN = -(wide_t'(1) <<< 23);

  // Same layout as out_tdata.
  typedef struct packed {
    logic [23:0] temperature;
    logic [31:0] pressure;
  } reading_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [bsc_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [bsc_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [bsc_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  // [23:0] raw_pressure, [47:24] raw_temperature
  logic [47:0]                in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  // [31:0] pressure_out, [55:32] temperature_out
  logic [55:0]                out_tdata;

  bsc_pkg::bsc_cfg_t active_cfg = '0;
  reading_t   expected_readings[$];
  int         mismatches = 0;
  logic       idle_on = 1'b1;
  logic       hold_out = 1'b0;
  int         rx_gap = 0;
  event       hold_request;

  baro_sensor_compensation_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Reading divided by the scale factor, as raw times a rounded reciprocal.
  function automatic wide_t scale_raw(input logic [23:0] raw, input logic [2:0] code);
    wide_t k, r, x;
    case (code)
      3'd0: k = 524288;
      3'd1: k = 1572864;
      3'd2: k = 3670016;
      3'd3: k = 7864320;
      3'd4: k = 253952;
      3'd5: k = 516096;
      3'd6: k = 1040384;
      default: k = 2088960;
    endcase
    r = ((wide_t'(1) <<< (FRAC + 24)) + k / 2) / k;
    x = wide_t'($signed(raw));
    return (x * r + (wide_t'(1) <<< 23)) >>> 24;
  endfunction

  // Product of two Q values, rounded on the magnitude so ties go away from zero.
  function automatic wide_t round_prod(input wide_t a, input wide_t b);
    logic  neg;
    wide_t ua, ub, m;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m = (ua * ub + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
    if (m > Q_SAT) m = Q_SAT;
    return neg ? -m : m;
  endfunction

  function automatic reading_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
    wide_t    one, p, t, c0, c1, c00, c10, c01, c11, c20, c21, c30;
    wide_t    a, b, e, g, pacc, tacc, pr, tr;
    reading_t r;
    one = wide_t'(1) <<< FRAC;
    c0  = wide_t'($signed(active_cfg.c0_c1[23:12]));
    c1  = wide_t'($signed(active_cfg.c0_c1[11:0]));
    c00 = wide_t'($signed(active_cfg.c00));
    c10 = wide_t'($signed(active_cfg.c10));
    c01 = wide_t'($signed(active_cfg.c01_c11[31:16]));
    c11 = wide_t'($signed(active_cfg.c01_c11[15:0]));
    c20 = wide_t'($signed(active_cfg.c20_c21_c30[47:32]));
    c21 = wide_t'($signed(active_cfg.c20_c21_c30[31:16]));
    c30 = wide_t'($signed(active_cfg.c20_c21_c30[15:0]));
    p = scale_raw(raw_p, active_cfg.p_osr);
    t = scale_raw(raw_t, active_cfg.t_osr);
    a = c20 * one + c30 * p;
    b = c10 * one + round_prod(p, a);
    e = c11 * one + c21 * p;
    g = c01 * one + round_prod(p, e);
    pacc = c00 * one + round_prod(p, b) + round_prod(t, g);
    tacc = c0 * (wide_t'(1) <<< (FRAC - 1)) + c1 * t;
    // Output rounding is to nearest with ties toward plus infinity.
    pr = (pacc + (wide_t'(1) <<< (FRAC - 7))) >>> (FRAC - 6);
    tr = (tacc + (wide_t'(1) <<< (FRAC - 9))) >>> (FRAC - 8);
    if (pr > P_MAX) pr = P_MAX;
    else if (pr < P_MIN) pr = P_MIN;
    if (tr > T_MAX) tr = T_MAX;
    else if (tr < T_MIN) tr = T_MIN;
    r.pressure = pr[31:0];
    r.temperature = tr[23:0];
    return r;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_out) begin
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(hold_request);
      hold_out <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_out <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    reading_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction %h", got));
      end else begin
        want = expected_readings.pop_front();
        if (got.pressure != want.pressure)
          report_mismatch($sformatf("pressure: expected %0d, got %0d",
                                    $signed(want.pressure), $signed(got.pressure)));
        if (got.temperature != want.temperature)
          report_mismatch($sformatf("temperature: expected %0d, got %0d",
                                    $signed(want.temperature), $signed(got.temperature)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int reg_width(input logic [bsc_pkg::CFG_IDX_W-1:0] idx);
    case (idx)
      bsc_pkg::REG_C0_C1:       return 24;
      bsc_pkg::REG_C00:         return 20;
      bsc_pkg::REG_C10:         return 20;
      bsc_pkg::REG_C01_C11:     return 32;
      bsc_pkg::REG_C20_C21_C30: return 48;
      bsc_pkg::REG_P_OSR:       return 3;
      bsc_pkg::REG_T_OSR:       return 3;
      default:                  return 0;
    endcase
  endfunction

  // Writes one register, sometimes with junk above its width, then reads back any but the unused one.
  task automatic write_reg(input logic [bsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    logic [63:0] wdata, mask;
    int          w;
    w = reg_width(idx);
    mask = (64'd1 << w) - 1;
    wdata = value & mask;
    if ($urandom_range(0, 1) == 1) wdata = wdata | ({$urandom, $urandom} << w);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      bsc_pkg::REG_C0_C1:       active_cfg.c0_c1 = wdata[23:0];
      bsc_pkg::REG_C00:         active_cfg.c00 = wdata[19:0];
      bsc_pkg::REG_C10:         active_cfg.c10 = wdata[19:0];
      bsc_pkg::REG_C01_C11:     active_cfg.c01_c11 = wdata[31:0];
      bsc_pkg::REG_C20_C21_C30: active_cfg.c20_c21_c30 = wdata[47:0];
      bsc_pkg::REG_P_OSR:       active_cfg.p_osr = wdata[2:0];
      bsc_pkg::REG_T_OSR:       active_cfg.t_osr = wdata[2:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if ((cfg_prdata & mask) != (value & mask))
        report_mismatch($sformatf("register %0d readback: expected %h, got %h",
                                  idx, value & mask, cfg_prdata & mask));
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    // The bus goes idle before the next transfer may start.
    @(posedge clk);
  endtask

  // Stops offering input and waits until every outstanding result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] c0_c1, input logic [19:0] c00,
                                input logic [19:0] c10, input logic [31:0] c01_c11,
                                input logic [47:0] c20_c21_c30, input logic [2:0] p_osr,
                                input logic [2:0] t_osr);
    drain();
    write_reg(bsc_pkg::REG_C0_C1, 64'(c0_c1));
    write_reg(bsc_pkg::REG_C00, 64'(c00));
    write_reg(bsc_pkg::REG_C10, 64'(c10));
    write_reg(bsc_pkg::REG_C01_C11, 64'(c01_c11));
    write_reg(bsc_pkg::REG_C20_C21_C30, 64'(c20_c21_c30));
    write_reg(bsc_pkg::REG_P_OSR, 64'(p_osr));
    write_reg(bsc_pkg::REG_T_OSR, 64'(t_osr));
  endtask

  // Coefficient of the given width, biased toward its extremes.
  function automatic logic [63:0] pick_coef(input int w);
    logic [63:0] mask;
    mask = (64'd1 << w) - 1;
    case ($urandom_range(0, 5))
      0: return mask >> 1;
      1: return (mask >> 1) + 1;
      2: return 64'd0;
      3: return mask;
      default: return {$urandom, $urandom} & mask;
    endcase
  endfunction

  task automatic randomize_settings();
    apply_settings(24'((pick_coef(12) << 12) | pick_coef(12)),
                   20'(pick_coef(20)),
                   20'(pick_coef(20)),
                   32'((pick_coef(16) << 16) | pick_coef(16)),
                   48'((pick_coef(16) << 32) | (pick_coef(16) << 16) | pick_coef(16)),
                   3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
  endtask

  function automatic logic [23:0] random_raw();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 1023));
      3: return ~24'($urandom_range(0, 1023));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [23:0] raw_p, input logic [23:0] raw_t);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {raw_t, raw_p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_readings.push_back(compensate(raw_p, raw_t));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pair(random_raw(), random_raw());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All coefficients are zero after reset, so both outputs must be zero.
  task automatic test_reset_defaults();
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h123456, 24'hFEDCBA);
    send_pair(24'h000000, 24'hFFFFFF);
  endtask

  task automatic test_field_extremes();
    apply_settings({12'h0D1, 12'hEFB}, 20'h13A1B, 20'hF2928, {16'hF4AC, 16'h04B0},
                   {16'hD8F0, 16'h00C8, 16'hFA24}, 3'd3, 3'd6);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000001, 24'h800000);
    send_pair(24'h7FFFFF, 24'h000001);
    send_pair(24'hF0D2A3, 24'h0FF3C1);
    send_pair(24'h555555, 24'hAAAAAA);
  endtask

  // The largest coefficients with the smallest scale factor drive both outputs
  // past their range in each direction.
  task automatic test_saturation();
    apply_settings({12'h7FF, 12'h7FF}, 20'h7FFFF, 20'h7FFFF, {16'h7FFF, 16'h7FFF},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF}, 3'd4, 3'd4);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'h7FFFFF, 24'h800000);
    apply_settings({12'h800, 12'h800}, 20'h80000, 20'h80000, {16'h8000, 16'h8000},
                   {16'h8000, 16'h8000, 16'h8000}, 3'd4, 3'd4);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
  endtask

  // A write past the last register must leave every setting as it was.
  task automatic test_unused_register();
    drain();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h012345);
    send_pair(random_raw(), random_raw());
  endtask

  task automatic test_oversampling_codes();
    for (int code = 0; code < 8; code++) begin
      drain();
      write_reg(bsc_pkg::REG_P_OSR, 64'(code));
      write_reg(bsc_pkg::REG_T_OSR, 64'(7 - code));
      send_random(4);
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 9; phase++) begin
      randomize_settings();
      idle_on <= ($urandom_range(0, 3) != 0);
      send_random(100);
    end
  endtask

  // The sender keeps offering while the output is held off, so the pipeline
  // fills and input transactions stall; then the sender waits for all results.
  task automatic test_output_stall();
    randomize_settings();
    idle_on <= 1'b0;
    -> hold_request;
    send_random(80);
    drain();
    idle_on <= 1'b1;
    send_random(20);
  endtask

  task automatic test_back_to_back();
    randomize_settings();
    idle_on <= 1'b0;
    send_random(150);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_saturation();
    test_unused_register();
    test_oversampling_codes();
    test_random_settings();
    test_output_stall();
    test_back_to_back();
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== baro_sensor_compensation_core.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_cfg_regs.sv
rtl/core/bsc_scale.sv
rtl/core/bsc_qmul.sv
rtl/core/baro_sensor_compensation_core.sv
test/tb_baro_sensor_compensation_core.sv
